// ----- rtl/wmd_pkg.sv -----
// shared types, widths and register indexes of the waveform min/max decimator
package wmd_pkg;

  // fixed field widths
  localparam int COUNT_W    = 24;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int ACC_W      = COUNT_W + COL_W;

  // parameter defaults
  localparam int DEF_SAMPLE_BITS      = 16;
  localparam int DEF_MAX_COLUMNS      = 4096;
  localparam int DEF_MAX_SAMPLE_COUNT = 16777216;
  localparam int DEF_MAX_POINTS       = 64;

  // floor(h*15/100) == (h*157290) >> 20 for every 12-bit h
  localparam int PAD_RECIP   = 157290;
  localparam int PAD_RECIP_W = 18;
  localparam int PAD_SHIFT   = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_HEIGHT  = 2'd2;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [COUNT_W-1:0] n_eff;
    logic [COL_W-1:0]   w_eff;
    logic [ROW_W-1:0]   pad;
    logic [ROW_W-1:0]   track;
    logic               restart;
  } cfg_t;

  // control part of a column word between sequencer and row stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             point_mode;
    logic             last;
    logic             done;
  } tok_ctrl_t;

endpackage

// ----- rtl/waveform_minmax_decimator_top.sv -----
// Min/max peak decimator for a waveform overview. Signed samples stream in on the
// sample channel and are mapped onto column_count display columns. When
// total_samples >= column_count each column gathers its share of samples and
// gives one bar word with the rows of its maximum and minimum; a sample is
// accepted every cycle while the output does not stall. When there are fewer
// samples than columns each sample gives one point word per column it covers,
// up to MAX_POINTS_PER_SAMPLE; the column sequencer walks one column per cycle
// unless the output stalls, and such a sample holds the input until its last
// column is stepped. A word passes the input register, the sequencer register,
// then row scaling into the output register. A register write restarts the
// frame and must be made while the block is idle.
module waveform_minmax_decimator_top import wmd_pkg::*; #(
  parameter int SAMPLE_BITS           = DEF_SAMPLE_BITS,
  parameter int MAX_COLUMNS           = DEF_MAX_COLUMNS,
  parameter int MAX_SAMPLE_COUNT      = DEF_MAX_SAMPLE_COUNT,
  parameter int MAX_POINTS_PER_SAMPLE = DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [COL_W-1:0]              column_x,
  output logic [ROW_W-1:0]              y_top,
  output logic [ROW_W-1:0]              y_bottom,
  output logic                          point_mode,
  output logic                          last_of_run,
  output logic                          frame_done
);

  cfg_t                          cfg;
  logic                          row_free;
  logic                          tok_valid;
  tok_ctrl_t                     tok_ctrl;
  logic signed [SAMPLE_BITS-1:0] tok_hi, tok_lo;

  // configuration
  wmd_cfg_regs #(
    .MAX_COLUMNS      (MAX_COLUMNS),
    .MAX_SAMPLE_COUNT (MAX_SAMPLE_COUNT)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // column sequencer
  wmd_engine #(
    .SAMPLE_BITS           (SAMPLE_BITS),
    .MAX_POINTS_PER_SAMPLE (MAX_POINTS_PER_SAMPLE)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .row_free     (row_free),
    .tok_valid    (tok_valid),
    .tok_ctrl     (tok_ctrl),
    .tok_hi       (tok_hi),
    .tok_lo       (tok_lo)
  );

  // row scaling and output
  wmd_row_map #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_row (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .tok_valid    (tok_valid),
    .tok_ctrl     (tok_ctrl),
    .tok_hi       (tok_hi),
    .tok_lo       (tok_lo),
    .row_free     (row_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .column_x     (column_x),
    .y_top        (y_top),
    .y_bottom     (y_bottom),
    .point_mode   (point_mode),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

  // a bar word always closes its sample
  a_bar_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !point_mode |-> last_of_run)
    else $error("bar word without last_of_run");

  // a point word carries one row
  a_point_row: assert property (@(posedge clk) disable iff (rst)
    result_valid && point_mode |-> y_top == y_bottom)
    else $error("point word with differing rows");

  // a pending sequencer word moves on once the output frees up
  a_tok_drain: assert property (@(posedge clk) disable iff (rst)
    tok_valid && row_free |=> result_valid)
    else $error("sequencer word lost on its way to the output");

endmodule

// ----- rtl/wmd_cfg_regs.sv -----
// configuration registers with saturation and padding/track precompute
module wmd_cfg_regs import wmd_pkg::*; #(
  parameter int MAX_COLUMNS      = DEF_MAX_COLUMNS,
  parameter int MAX_SAMPLE_COUNT = DEF_MAX_SAMPLE_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [COUNT_W-1:0] n_eff, n_next, n_raw;
  logic [COL_W-1:0]   w_eff, w_next, w_raw;
  logic [ROW_W-1:0]   pad, pad_next, track, track_next, h;
  logic [ROW_W+PAD_RECIP_W-1:0] pad_prod;

  // clamp counts, zero acts as one
  always_comb begin
    n_raw = cfg_data[COUNT_W-1:0];
    w_raw = cfg_data[COL_W-1:0];
    h     = cfg_data[ROW_W-1:0];
    if (n_raw == '0) begin
      n_next = COUNT_W'(1);
    end else if (32'(n_raw) > 32'(MAX_SAMPLE_COUNT - 1)) begin
      n_next = COUNT_W'(MAX_SAMPLE_COUNT - 1);
    end else begin
      n_next = n_raw;
    end
    if (w_raw == '0) begin
      w_next = COL_W'(1);
    end else if (32'(w_raw) > 32'(MAX_COLUMNS - 1)) begin
      w_next = COL_W'(MAX_COLUMNS - 1);
    end else begin
      w_next = w_raw;
    end
    pad_prod   = (ROW_W+PAD_RECIP_W)'(h) * (ROW_W+PAD_RECIP_W)'(PAD_RECIP);
    pad_next   = ROW_W'(pad_prod >> PAD_SHIFT);
    track_next = h - (pad_next << 1);
  end

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      n_eff <= COUNT_W'(1);
      w_eff <= COL_W'(1);
      pad   <= '0;
      track <= ROW_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOTAL_SAMPLES: n_eff <= n_next;
        REG_COLUMN_COUNT:  w_eff <= w_next;
        REG_PIXEL_HEIGHT: begin
          pad   <= pad_next;
          track <= track_next;
        end
        default: ;
      endcase
    end
  end

  // any write restarts the frame
  always_comb begin
    cfg.n_eff   = n_eff;
    cfg.w_eff   = w_eff;
    cfg.pad     = pad;
    cfg.track   = track;
    cfg.restart = cfg_write;
  end

endmodule

// ----- rtl/wmd_engine.sv -----
// input register and column sequencer: min/max gathering and point expansion
module wmd_engine import wmd_pkg::*; #(
  parameter int SAMPLE_BITS           = DEF_SAMPLE_BITS,
  parameter int MAX_POINTS_PER_SAMPLE = DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          row_free,
  output logic                          tok_valid,
  output tok_ctrl_t                     tok_ctrl,
  output logic signed [SAMPLE_BITS-1:0] tok_hi,
  output logic signed [SAMPLE_BITS-1:0] tok_lo
);

  localparam int CNT_W = $clog2(MAX_POINTS_PER_SAMPLE + 1);
  localparam logic [CNT_W-1:0] CAP      = CNT_W'(MAX_POINTS_PER_SAMPLE);
  localparam logic [CNT_W-1:0] CAP_LAST = CNT_W'(MAX_POINTS_PER_SAMPLE - 1);
  localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                          in_full;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [COL_W-1:0]              col;
  logic [ACC_W-1:0]              csa, ssa;
  logic [COUNT_W-1:0]            pos;
  logic signed [SAMPLE_BITS-1:0] rmin, rmax, new_min, new_max;
  logic [CNT_W-1:0]              cnt;

  logic [ACC_W:0]   w_ext, n_ext, ssa_w, ssa_2w, csa_n;
  logic [COL_W:0]   w13, col_inc, col_after;
  logic [COUNT_W:0] pos_inc;
  logic bar_mode, pt_cond, pt_next, bar_emit, pt_emit;
  logic fire, finish, emit, advance, frame_end, tok_free;

  // column boundary arithmetic
  always_comb begin
    w_ext    = (ACC_W+1)'(cfg.w_eff);
    n_ext    = (ACC_W+1)'(cfg.n_eff);
    ssa_w    = {1'b0, ssa} + w_ext;
    ssa_2w   = ssa_w + w_ext;
    csa_n    = {1'b0, csa} + n_ext;
    w13      = {1'b0, cfg.w_eff};
    col_inc  = {1'b0, col} + (COL_W+1)'(1);
    pos_inc  = {1'b0, pos} + (COUNT_W+1)'(1);
    bar_mode = cfg.n_eff >= COUNT_W'(cfg.w_eff);
    pt_cond  = ({1'b0, col} < w13) && ({1'b0, csa} < ssa_w);
    pt_next  = (col_inc < w13) && (csa_n < ssa_w);
    bar_emit = csa_n < ssa_2w;
    pt_emit  = pt_cond && (cnt < CAP);
    new_min  = (in_sample < rmin) ? in_sample : rmin;
    new_max  = (in_sample > rmax) ? in_sample : rmax;
  end

  assign tok_free = !tok_valid || row_free;

  // step control: bar mode one step per sample, point mode one step per column
  always_comb begin
    fire    = 1'b0;
    finish  = 1'b0;
    emit    = 1'b0;
    advance = 1'b0;
    if (in_full) begin
      if (bar_mode) begin
        fire    = tok_free;
        finish  = 1'b1;
        emit    = bar_emit;
        advance = bar_emit;
      end else if (pt_cond) begin
        emit    = pt_emit;
        fire    = !pt_emit || tok_free;
        finish  = !pt_next;
        advance = 1'b1;
      end else begin
        fire   = 1'b1;
        finish = 1'b1;
      end
    end
    col_after = advance ? col_inc : {1'b0, col};
    frame_end = finish && ((col_after >= w13) || (pos_inc >= {1'b0, cfg.n_eff}));
  end

  assign sample_ready = !in_full || (fire && finish);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      tok_valid <= 1'b0;
      col       <= '0;
      csa       <= '0;
      ssa       <= '0;
      pos       <= '0;
      rmin      <= VAL_MAX;
      rmax      <= VAL_MIN;
      cnt       <= '0;
    end else begin
      if (sample_ready) begin
        in_full <= sample_valid;
      end
      if (fire && emit) begin
        tok_valid <= 1'b1;
      end else if (row_free) begin
        tok_valid <= 1'b0;
      end
      if (cfg.restart || (fire && frame_end)) begin
        col  <= '0;
        csa  <= '0;
        ssa  <= '0;
        pos  <= '0;
        rmin <= VAL_MAX;
        rmax <= VAL_MIN;
        cnt  <= '0;
      end else if (fire) begin
        if (advance) begin
          col <= col_inc[COL_W-1:0];
          csa <= csa_n[ACC_W-1:0];
        end
        if (bar_mode) begin
          if (bar_emit) begin
            rmin <= VAL_MAX;
            rmax <= VAL_MIN;
          end else begin
            rmin <= new_min;
            rmax <= new_max;
          end
        end
        // sample done: move on, else count the point columns stepped
        if (finish) begin
          ssa <= ssa_w[ACC_W-1:0];
          pos <= pos_inc[COUNT_W-1:0];
          cnt <= '0;
        end else if (advance && (cnt < CAP)) begin
          cnt <= cnt + CNT_W'(1);
        end
      end
    end
  end

  // sample and column word payload
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      in_sample <= sample_value;
    end
    if (fire && emit) begin
      tok_ctrl.col        <= col;
      tok_ctrl.point_mode <= !bar_mode;
      tok_ctrl.last       <= bar_mode || finish || (cnt == CAP_LAST);
      tok_ctrl.done       <= (col_inc == w13);
      tok_hi              <= bar_mode ? new_max : in_sample;
      tok_lo              <= bar_mode ? new_min : in_sample;
    end
  end

endmodule

// ----- rtl/wmd_row_map.sv -----
// sample to pixel row scaling and output register
module wmd_row_map import wmd_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cfg_t                          cfg,
  input  logic                          tok_valid,
  input  tok_ctrl_t                     tok_ctrl,
  input  logic signed [SAMPLE_BITS-1:0] tok_hi,
  input  logic signed [SAMPLE_BITS-1:0] tok_lo,
  output logic                          row_free,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [COL_W-1:0]              column_x,
  output logic [ROW_W-1:0]              y_top,
  output logic [ROW_W-1:0]              y_bottom,
  output logic                          point_mode,
  output logic                          last_of_run,
  output logic                          frame_done
);

  localparam int PROD_W = SAMPLE_BITS + ROW_W + 1;
  localparam logic [SAMPLE_BITS:0] HALF = {2'b01, {(SAMPLE_BITS-1){1'b0}}};

  // row = pad + ((half - v) * track) >> SAMPLE_BITS
  function automatic logic [ROW_W-1:0] row_of(input logic signed [SAMPLE_BITS-1:0] v,
                                              input logic [ROW_W-1:0] pad,
                                              input logic [ROW_W-1:0] track);
    logic [SAMPLE_BITS:0] off;
    logic [PROD_W-1:0]    prod;
    logic [ROW_W:0]       sum;
    off  = HALF - {v[SAMPLE_BITS-1], v};
    prod = PROD_W'(off) * PROD_W'(track);
    sum  = (ROW_W+1)'(pad) + (ROW_W+1)'(prod >> SAMPLE_BITS);
    return sum[ROW_W-1:0];
  endfunction

  logic take;

  assign row_free = !result_valid || result_ready;
  assign take     = tok_valid && row_free;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (row_free) begin
      result_valid <= tok_valid;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (take) begin
      column_x    <= tok_ctrl.col;
      y_top       <= row_of(tok_hi, cfg.pad, cfg.track);
      y_bottom    <= row_of(tok_lo, cfg.pad, cfg.track);
      point_mode  <= tok_ctrl.point_mode;
      last_of_run <= tok_ctrl.last;
      frame_done  <= tok_ctrl.done;
    end
  end

endmodule

// ----- verif/wmd_column_checker.sv -----
// column word checker: tracks the decimator state, predicts each word and compares
module wmd_column_checker import wmd_pkg::*; (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [CFG_IDX_W-1:0]              cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              sample_valid,
  input  logic                              sample_ready,
  input  logic signed [DEF_SAMPLE_BITS-1:0] sample_value,
  input  logic                              result_valid,
  input  logic                              result_ready,
  input  logic [COL_W-1:0]                  column_x,
  input  logic [ROW_W-1:0]                  y_top,
  input  logic [ROW_W-1:0]                  y_bottom,
  input  logic                              point_mode,
  input  logic                              last_of_run,
  input  logic                              frame_done,
  output int                                pending,
  output int                                mismatches
);

  localparam longint HALF_SCALE   = longint'(1) << (DEF_SAMPLE_BITS - 1);

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] top;
    logic [ROW_W-1:0] bot;
    logic             pm;
    logic             last;
    logic             done;
  } column_word_t;

  column_word_t expected_words[$];

  // shadow registers
  logic [COUNT_W-1:0] total_reg;
  logic [COL_W-1:0]   columns_reg;
  logic [ROW_W-1:0]   height_reg;

  // frame progress
  longint unsigned samples_seen;
  longint unsigned next_column;
  longint unsigned sample_acc;
  longint unsigned column_acc;
  longint          col_min;
  longint          col_max;

  int mismatch_total = 0;
  int words_checked  = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_total++;
  endtask

  function automatic void frame_clear();
    samples_seen = 0;
    next_column  = 0;
    sample_acc   = 0;
    column_acc   = 0;
    col_min      = 32767;
    col_max      = -32768;
  endfunction

  // row of a sample: padding plus its share of the track
  function automatic logic [ROW_W-1:0] row_for(input longint v);
    longint unsigned h, pad, track, off;
    h     = height_reg;
    pad   = (h * 15) / 100;
    track = h - 2 * pad;
    off   = longint'(HALF_SCALE - v);
    return ROW_W'(pad + ((off * track) >> DEF_SAMPLE_BITS));
  endfunction

  // one sample in, zero or more column words out
  function automatic void decimate_sample(input logic signed [DEF_SAMPLE_BITS-1:0] raw);
    longint          v;
    longint unsigned n, w;
    logic [ROW_W-1:0] y;
    int              emitted;
    column_word_t    word;
    v = raw;
    n = (total_reg == 0) ? 1 : total_reg;
    if (n > DEF_MAX_SAMPLE_COUNT - 1) n = DEF_MAX_SAMPLE_COUNT - 1;
    w = (columns_reg == 0) ? 1 : columns_reg;
    if (w > DEF_MAX_COLUMNS - 1) w = DEF_MAX_COLUMNS - 1;
    emitted = 0;
    if (n >= w) begin
      // bar mode: gather, close the column on its last sample
      if (v < col_min) col_min = v;
      if (v > col_max) col_max = v;
      sample_acc += w;
      samples_seen++;
      if (column_acc + n < sample_acc + w) begin
        word.col  = COL_W'(next_column);
        word.top  = row_for(col_max);
        word.bot  = row_for(col_min);
        word.pm   = 1'b0;
        word.last = 1'b1;
        word.done = (next_column + 1 == w);
        expected_words.push_back(word);
        col_min = 32767;
        col_max = -32768;
        next_column++;
        column_acc += n;
      end
    end else begin
      // point mode: one word per column that picks this sample, capped
      y = row_for(v);
      while (next_column < w && column_acc < sample_acc + w) begin
        if (emitted < DEF_MAX_POINTS) begin
          word.col  = COL_W'(next_column);
          word.top  = y;
          word.bot  = y;
          word.pm   = 1'b1;
          word.last = 1'b0;
          word.done = (next_column + 1 == w);
          expected_words.push_back(word);
          emitted++;
        end
        next_column++;
        column_acc += n;
      end
      if (emitted > 0) expected_words[expected_words.size() - 1].last = 1'b1;
      sample_acc += w;
      samples_seen++;
    end
    // frame end
    if (next_column >= w || samples_seen >= n) frame_clear();
  endfunction

  always @(posedge clk) begin
    column_word_t got, want;
    if (rst) begin
      total_reg   = 1;
      columns_reg = 1;
      height_reg  = 1;
      frame_clear();
      expected_words.delete();
    end else begin
      // outgoing word against the oldest prediction
      if (result_valid && result_ready) begin
        got = {column_x, y_top, y_bottom, point_mode, last_of_run, frame_done};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %0d unexpected: x=%0d top=%0d bot=%0d",
                                    words_checked, column_x, y_top, y_bottom));
        end else begin
          want = expected_words.pop_front();
          if (got !== want)
            report_mismatch($sformatf(
              {"word %0d got x=%0d t=%0d b=%0d pm=%b l=%b d=%b",
               " want x=%0d t=%0d b=%0d pm=%b l=%b d=%b"},
              words_checked, got.col, got.top, got.bot, got.pm, got.last, got.done,
              want.col, want.top, want.bot, want.pm, want.last, want.done));
        end
        words_checked++;
      end
      // register write restarts the frame
      if (cfg_write) begin
        case (cfg_index)
          REG_TOTAL_SAMPLES: total_reg   = cfg_data[COUNT_W-1:0];
          REG_COLUMN_COUNT:  columns_reg = cfg_data[COL_W-1:0];
          REG_PIXEL_HEIGHT:  height_reg  = cfg_data[ROW_W-1:0];
          default: ;
        endcase
        frame_clear();
      end else if (sample_valid && sample_ready) begin
        decimate_sample(sample_value);
      end
    end
    pending    <= expected_words.size();
    mismatches <= mismatch_total;
  end

endmodule

// ----- verif/tb_waveform_minmax_decimator_top.sv -----
// testbench top: clock, reset, sample and register stimulus, receiver stalls and verdict
module tb_waveform_minmax_decimator_top;
  import wmd_pkg::*;

  localparam int QUIET_LIMIT = 30000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                              clk = 1'b0;
  logic                              rst;
  logic                              cfg_write;
  logic [CFG_IDX_W-1:0]              cfg_index;
  logic [CFG_DATA_W-1:0]             cfg_data;
  logic                              sample_valid;
  logic                              sample_ready;
  logic signed [DEF_SAMPLE_BITS-1:0] sample_value;
  logic                              result_valid;
  logic                              result_ready;
  logic [COL_W-1:0]                  column_x;
  logic [ROW_W-1:0]                  y_top;
  logic [ROW_W-1:0]                  y_bottom;
  logic                              point_mode;
  logic                              last_of_run;
  logic                              frame_done;

  int pending;
  int mismatches;
  int quiet_cycles = 0;
  int hold_token   = 0;
  int ready_style  = 0;

  waveform_minmax_decimator_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .column_x     (column_x),
    .y_top        (y_top),
    .y_bottom     (y_bottom),
    .point_mode   (point_mode),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

  wmd_column_checker column_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_value (sample_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .column_x     (column_x),
    .y_top        (y_top),
    .y_bottom     (y_bottom),
    .point_mode   (point_mode),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done),
    .pending      (pending),
    .mismatches   (mismatches)
  );

  always #4 clk = ~clk;

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_waveform_minmax_decimator_top: errors");
        $finish;
      end
    end
  end

  // receiver: stall pattern per phase, long hold on request
  initial begin
    int hold_seen;
    hold_seen    = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (ready_style)
          0: result_ready <= 1'b1;
          1: result_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            result_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            result_ready <= 1'b1;
            repeat ($urandom_range(0, 9)) @(posedge clk);
          end
        endcase
      end
    end
  end

  // hold one sample word until taken; entered and left on a rising edge
  task automatic offer_sample(input logic signed [DEF_SAMPLE_BITS-1:0] v);
    sample_valid <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (!sample_ready);
  endtask

  // write all three registers back to back, optionally the spare index last
  task automatic program_frame(input logic [CFG_DATA_W-1:0] n_data,
                               input logic [CFG_DATA_W-1:0] w_data,
                               input logic [CFG_DATA_W-1:0] h_data,
                               input bit spare);
    cfg_write <= 1'b1;
    cfg_index <= REG_TOTAL_SAMPLES;
    cfg_data  <= n_data;
    @(posedge clk);
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data  <= w_data;
    @(posedge clk);
    cfg_index <= REG_PIXEL_HEIGHT;
    cfg_data  <= h_data;
    @(posedge clk);
    if (spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= 24'(signed'($urandom));
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every predicted word, then let the pipeline go quiet
  task automatic drain(input int extra);
    do @(posedge clk); while (pending != 0);
    repeat (extra) @(posedge clk);
  endtask

  // random samples with bursts, a mid-phase pause and an optional long hold
  task automatic stream_samples(input int count, input bit bursty, input bit pressure);
    int burst_left;
    logic signed [DEF_SAMPLE_BITS-1:0] v;
    burst_left = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end else begin
        v = 16'($urandom);
      end
      if (pressure && i == 10) hold_token <= hold_token + 1;
      offer_sample(v);
      if (i == count / 2) begin
        sample_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end else if (bursty) begin
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          sample_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
          burst_left = $urandom_range(1, 12);
        end
      end
    end
    sample_valid <= 1'b0;
  endtask

  initial begin
    logic signed [DEF_SAMPLE_BITS-1:0] bar_vals[8];
    int n, w, h, count;
    bar_vals = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                 16'sh0001, 16'sh8001, 16'sh4000, 16'shC000};
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bar mode, two samples per column, extremes of the sample range
    ready_style <= 1;
    program_frame(24'd8, 24'd4, 24'd100, 1'b0);
    foreach (bar_vals[i]) offer_sample(bar_vals[i]);
    sample_valid <= 1'b0;
    drain(12);

    // point mode at full height
    program_frame(24'd3, 24'd10, 24'd4095, 1'b0);
    offer_sample(16'sh7FFF);
    offer_sample(16'sh8000);
    offer_sample(16'sh0000);
    sample_valid <= 1'b0;
    drain(20);

    // zero counts act as one, zero height gives row 0; masked upper bits
    program_frame(24'h000000, 24'hABC000, 24'h5A5000, 1'b1);
    offer_sample(16'sh7FFF);
    offer_sample(16'sh8000);
    sample_valid <= 1'b0;
    drain(12);

    // point cap: each sample covers far more columns than it may emit
    program_frame(24'd2, 24'h000FFF, 24'd1, 1'b0);
    offer_sample(16'sh8000);
    offer_sample(16'sh7FFF);
    sample_valid <= 1'b0;
    drain(4200);

    // largest frame: no column completes
    program_frame(24'hFFFFFF, 24'hFFFFFF, 24'h000FFF, 1'b1);
    offer_sample(16'sh3039);
    offer_sample(16'shFFFE);
    offer_sample(16'sh7FFF);
    sample_valid <= 1'b0;
    drain(12);

    // random phases: bar, point, capped point
    for (int p = 0; p < 9; p++) begin
      case (p % 3)
        0: begin
          w = $urandom_range(1, 40);
          n = w + $urandom_range(0, 3 * w);
          count = 80;
        end
        1: begin
          n = $urandom_range(1, 20);
          w = n + $urandom_range(1, 200);
          count = 80;
        end
        default: begin
          n = $urandom_range(1, 6);
          w = $urandom_range(600, 4095);
          count = 12;
        end
      endcase
      h = $urandom_range(0, 4095);
      ready_style <= $urandom_range(0, 2);
      program_frame(24'(n), {12'($urandom), 12'(w)}, {12'($urandom), 12'(h)},
                    $urandom_range(0, 3) == 0);
      stream_samples(count, $urandom_range(0, 3) != 0, p < 2);
      drain(w + 8);
    end

    drain(16);
    if (mismatches == 0) begin
      $display("tb_waveform_minmax_decimator_top: clean");
    end else begin
      $display("tb_waveform_minmax_decimator_top: errors");
    end
    $finish;
  end

endmodule
